FILE: design/dvcl_pkg.sv
// Shared types and constants for the dq voltage circle limiter.
// No dependencies; all other design files refer to it by scoped names.
package dvcl_pkg;

  localparam int unsigned VoltW = 16;       // signed Q5.10 voltage
  localparam int unsigned VmaxW = 15;       // unsigned Q5.10 radius
  localparam int unsigned SqW   = 31;       // squares and remainder, Q11.20
  localparam int unsigned RootW = 15;       // floor square root width

  localparam logic [VmaxW-1:0] VmaxReset = 15'd14090;  // 13.76 V

  // Per-item sideband carried down the pipe
  typedef struct packed {
    logic [VoltW-1:0] ud;
    logic [VoltW-1:0] uq;       // original uq, for pass-through
    logic             uq_pos;   // uq strictly positive
    logic             lim;      // vector outside the circle
    logic             clamp;    // no room left for uq, clamp ud
  } dvcl_side_t;

  // Payload of one square-root stage
  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
    dvcl_side_t       side;
  } dvcl_sq_t;

endpackage

FILE: design/dvcl_front.sv
// Front end: squares of ud, uq and vmax, then the circle test and the room
// left for uq. Two register stages. Depends on dvcl_pkg.
module dvcl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dvcl_pkg::VmaxW-1:0]     vmax_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dvcl_pkg::VoltW-1:0]     ud_i,
  input  logic [dvcl_pkg::VoltW-1:0]     uq_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dvcl_pkg::dvcl_sq_t             out_data_o
);

  // stage 1: squares
  logic                          v1_q;
  logic                          rdy1;
  logic [dvcl_pkg::SqW-1:0]      sq_d_q, sq_q_q, sq_v_q;
  logic [dvcl_pkg::VoltW-1:0]    ud1_q, uq1_q;
  logic [2*dvcl_pkg::VoltW-1:0]  prod_d, prod_q;
  logic [2*dvcl_pkg::VmaxW-1:0]  prod_v;

  // stage 2: compare
  logic                          v2_q;
  logic                          rdy2;
  dvcl_pkg::dvcl_sq_t            d2_q;
  logic [dvcl_pkg::SqW:0]        sum_dq;
  logic [dvcl_pkg::SqW:0]        room;
  logic                          room_pos;
  logic                          lim;
  dvcl_pkg::dvcl_sq_t            d2_d;

  assign rdy2       = ~v2_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  assign prod_d = $signed(ud_i) * $signed(ud_i);
  assign prod_q = $signed(uq_i) * $signed(uq_i);
  assign prod_v = vmax_i * vmax_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      sq_d_q <= prod_d[dvcl_pkg::SqW-1:0];
      sq_q_q <= prod_q[dvcl_pkg::SqW-1:0];
      sq_v_q <= {1'b0, prod_v};
      ud1_q  <= ud_i;
      uq1_q  <= uq_i;
    end
  end

  always_comb begin
    sum_dq   = {1'b0, sq_d_q} + {1'b0, sq_q_q};
    lim      = sum_dq > {1'b0, sq_v_q};
    // two's complement difference, sign in the top bit
    room     = {1'b0, sq_v_q} - {1'b0, sq_d_q};
    room_pos = ~room[dvcl_pkg::SqW] && (room != '0);

    d2_d.rem         = room_pos ? room[dvcl_pkg::SqW-1:0] : '0;
    d2_d.root        = '0;
    d2_d.side.ud     = ud1_q;
    d2_d.side.uq     = uq1_q;
    d2_d.side.uq_pos = ~uq1_q[dvcl_pkg::VoltW-1] && (uq1_q != '0);
    d2_d.side.lim    = lim;
    d2_d.side.clamp  = lim && !room_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      d2_q <= d2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = d2_q;

endmodule

FILE: design/dvcl_sqrt_step.sv
// One stage of the pipelined floor square root: decides root bit BitIdx.
// Keeps rem = room - root^2. Depends on dvcl_pkg.
module dvcl_sqrt_step #(
  parameter int unsigned BitIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dvcl_pkg::dvcl_sq_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dvcl_pkg::dvcl_sq_t out_data_o
);

  logic                     valid_q;
  dvcl_pkg::dvcl_sq_t       data_q;
  dvcl_pkg::dvcl_sq_t       data_d;
  logic [dvcl_pkg::SqW-1:0] trial;
  logic                     take;

  assign in_ready_o = ~valid_q | out_ready_i;

  // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i)
  always_comb begin
    trial  = (dvcl_pkg::SqW'(in_data_i.root) << (BitIdx + 1))
           + (dvcl_pkg::SqW'(1) << (2 * BitIdx));
    take   = in_data_i.rem >= trial;
    data_d = in_data_i;
    if (take) begin
      data_d.rem          = in_data_i.rem - trial;
      data_d.root[BitIdx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: design/dvcl_format.sv
// Output stage: picks pass-through, d-axis clamp or signed root for uq.
// Registered result item. Depends on dvcl_pkg.
module dvcl_format (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dvcl_pkg::VmaxW-1:0] vmax_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  dvcl_pkg::dvcl_sq_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dvcl_pkg::VoltW-1:0] ud_o,
  output logic [dvcl_pkg::VoltW-1:0] uq_o,
  output logic                       lim_o
);

  logic                       valid_q;
  logic [dvcl_pkg::VoltW-1:0] ud_q, uq_q, ud_d, uq_d;
  logic                       lim_q;
  logic [dvcl_pkg::VoltW-1:0] vmax_x, root_x;
  logic                       ud_pos;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    vmax_x = {1'b0, vmax_i};
    root_x = {1'b0, in_data_i.root};
    ud_pos = ~in_data_i.side.ud[dvcl_pkg::VoltW-1] && (in_data_i.side.ud != '0);
    ud_d   = in_data_i.side.ud;
    uq_d   = in_data_i.side.uq;
    if (in_data_i.side.clamp) begin
      ud_d = ud_pos ? vmax_x : dvcl_pkg::VoltW'(0) - vmax_x;
      uq_d = '0;
    end else if (in_data_i.side.lim) begin
      // zero uq takes the negative branch, giving zero or -root
      uq_d = in_data_i.side.uq_pos ? root_x : dvcl_pkg::VoltW'(0) - root_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ud_q  <= ud_d;
      uq_q  <= uq_d;
      lim_q <= in_data_i.side.lim;
    end
  end

  assign out_valid_o = valid_q;
  assign ud_o        = ud_q;
  assign uq_o        = uq_q;
  assign lim_o       = lim_q;

endmodule

FILE: design/dq_voltage_circle_limiter.sv
// dq voltage circle limiter, top level. Uses dvcl_pkg, dvcl_front,
// dvcl_sqrt_step and dvcl_format.
//
// Limits a signed Q5.10 (ud, uq) pair to a circle of radius vmax with the
// d axis taking priority: ud passes unless it alone exceeds the circle, in
// which case it is clamped to +/-vmax and uq is zeroed; otherwise uq becomes
// the signed floor square root of vmax^2 - ud^2 if limited. tuser flags a
// limited item. One item enters per clock unless the output stalls. It has two
// front stages (squares, circle test), one stage per root bit of the 15-bit
// square root, and the output register. Each stage holds its own valid bit, so
// bubbles collapse and an input item is taken while a result waits as long as
// a stage is free. vmax must be written only while no item is in flight.
module dq_voltage_circle_limiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: vmax, 15-bit unsigned Q5.10
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] ud_in, [31:16] uq_in
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] ud_out, [31:16] uq_out
  output logic [0:0]  m_axis_tuser    // [0] limited
);

  localparam int unsigned NSteps = dvcl_pkg::RootW;

  logic [dvcl_pkg::VmaxW-1:0] vmax_q;

  logic               st_valid [NSteps+1];
  logic               st_ready [NSteps+1];
  dvcl_pkg::dvcl_sq_t st_data  [NSteps+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q <= dvcl_pkg::VmaxReset;
    end else if (cfg_valid_i) begin
      vmax_q <= cfg_data_i;
    end
  end

  dvcl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vmax_i      (vmax_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ud_i        (s_axis_tdata[15:0]),
    .uq_i        (s_axis_tdata[31:16]),
    .out_valid_o (st_valid[0]),
    .out_ready_i (st_ready[0]),
    .out_data_o  (st_data[0])
  );

  // most significant root bit first
  for (genvar k = 0; k < NSteps; k++) begin : g_sqrt
    dvcl_sqrt_step #(
      .BitIdx(NSteps - 1 - k)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[k]),
      .in_ready_o  (st_ready[k]),
      .in_data_i   (st_data[k]),
      .out_valid_o (st_valid[k+1]),
      .out_ready_i (st_ready[k+1]),
      .out_data_o  (st_data[k+1])
    );
  end

  // the original uq travels in the sideband for pass-through items
  dvcl_format u_format (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vmax_i      (vmax_q),
    .in_valid_i  (st_valid[NSteps]),
    .in_ready_o  (st_ready[NSteps]),
    .in_data_i   (st_data[NSteps]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ud_o        (m_axis_tdata[15:0]),
    .uq_o        (m_axis_tdata[31:16]),
    .lim_o       (m_axis_tuser[0])
  );

endmodule

FILE: bench/dq_voltage_circle_limiter_tb.sv
// Testbench for dq_voltage_circle_limiter: drives voltage pairs and radius writes,
// predicts each limited pair and checks it. Needs dvcl_pkg and the limiter RTL.
module dq_voltage_circle_limiter_tb;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 240;
  localparam int SegItems   = 106;

  typedef struct packed {
    logic [15:0] ud;
    logic [15:0] uq;
    logic        lim;
  } limit_res_t;

  typedef struct {
    int vmax;
    int ud;
    int uq;
    bit known;
    int eud;
    int euq;
    bit elim;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] ud_in, [31:16] uq_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] ud_out, [31:16] uq_out
  logic [0:0]  m_axis_tuser;   // [0] limited

  limit_res_t  limit_q[$];
  logic [14:0] radius;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_req;
  int          mismatches, results_seen, cycle_count, cfg_writes;

  // vmax column uses the reset radius, zero and full scale
  localparam int VR = int'(dvcl_pkg::VmaxReset);
  dir_row_t dir_rows [26] = '{
    '{VR,      0,      0, 1,      0,      0, 0},
    '{VR,  14090,      0, 1,  14090,      0, 0},
    '{VR,  14091,      0, 1,  14090,      0, 1},
    '{VR, -14091,      0, 1, -14090,      0, 1},
    '{VR,      0,  14090, 1,      0,  14090, 0},
    '{VR,      0,  14091, 1,      0,  14090, 1},
    '{VR,      0, -32768, 1,      0, -14090, 1},
    '{VR,  32767,  32767, 1,  14090,      0, 1},
    '{VR, -32768, -32768, 1, -14090,      0, 1},
    '{VR, -32768,  32767, 1, -14090,      0, 1},
    '{VR,  20000,      0, 1,  14090,      0, 1},   // zero uq under clamp
    '{VR,  10000,  12000, 0,      0,      0, 0},
    '{VR, -10000, -12000, 0,      0,      0, 0},
    '{VR,     -1,  32767, 0,      0,      0, 0},
    '{VR,   9963,   9963, 0,      0,      0, 0},
    '{VR,   9964,   9964, 0,      0,      0, 0},
    '{0,       0,      0, 1,      0,      0, 0},    // zero radius
    '{0,       1,      0, 1,      0,      0, 1},
    '{0,  -32768,      5, 1,      0,      0, 1},
    '{0,       0,     -1, 1,      0,      0, 1},
    '{32767, 32767,      0, 1,  32767,      0, 0},
    '{32767, -32768,     0, 1, -32767,      0, 1},
    '{32767,     0, -32768, 1,      0, -32767, 1},
    '{32767, 32767,      1, 1,  32767,      0, 1},
    '{32767, -32768, -32768, 1, -32767,     0, 1},
    '{32767,  1234, -30000, 0,      0,      0, 0}
  };

  dq_voltage_circle_limiter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, limit_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // floor square root; operand stays below 2^31
  function automatic longint root_floor(input longint x);
    longint r, t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // d axis keeps priority; uq gets what room is left inside the circle
  function automatic limit_res_t limit_pair(input logic signed [15:0] ud,
                                            input logic signed [15:0] uq,
                                            input logic [14:0] rad);
    longint sq_d, sq_q, sq_v, room;
    int clamp_v, mag;
    limit_res_t r;
    sq_d = longint'(ud) * longint'(ud);
    sq_q = longint'(uq) * longint'(uq);
    sq_v = longint'(rad) * longint'(rad);
    r.ud = ud;
    r.uq = uq;
    r.lim = 1'b0;
    if (sq_v - sq_d - sq_q < 0) begin
      room = sq_v - sq_d;
      if (room <= 0) begin
        clamp_v = (ud > 0) ? int'(rad) : -int'(rad);
        r.ud = clamp_v[15:0];
        r.uq = '0;
      end else begin
        mag = int'(root_floor(room));
        mag = (uq > 0) ? mag : -mag;
        r.uq = mag[15:0];
      end
      r.lim = 1'b1;
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: %s expected %0d, got %0d",
               cycle_count, what, exp_v, act_v);
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin : recv_proc
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_blk
    limit_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (limit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: ud %0d uq %0d lim %0b", cycle_count,
                   $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tuser[0]);
      end else begin
        e = limit_q.pop_front();
        if (m_axis_tdata[15:0] !== e.ud)
          note_mismatch("ud_out", $signed(e.ud), $signed(m_axis_tdata[15:0]));
        if (m_axis_tdata[31:16] !== e.uq)
          note_mismatch("uq_out", $signed(e.uq), $signed(m_axis_tdata[31:16]));
        if (m_axis_tuser[0] !== e.lim)
          note_mismatch("limited", int'(e.lim), int'(m_axis_tuser[0]));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pair(input logic [15:0] ud, input logic [15:0] uq, input limit_res_t e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {uq, ud};
    do @(posedge clk_i); while (!s_axis_tready);
    limit_q.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (limit_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_radius(input logic [14:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    radius = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stim_proc
    limit_res_t e;
    int ud_v, uq_v, r_v, v;
    int rand_items;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    cycle_count   = 0;
    cfg_writes    = 0;
    rand_items    = 0;
    radius        = dvcl_pkg::VmaxReset;
    send_idle_pct = 38;
    recv_idle_pct = 49;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].vmax != int'(radius)) set_radius(dir_rows[i].vmax[14:0]);
      if (dir_rows[i].known) begin
        e.ud  = dir_rows[i].eud[15:0];
        e.uq  = dir_rows[i].euq[15:0];
        e.lim = dir_rows[i].elim;
      end else begin
        e = limit_pair(dir_rows[i].ud[15:0], dir_rows[i].uq[15:0], radius);
      end
      send_pair(dir_rows[i].ud[15:0], dir_rows[i].uq[15:0], e);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 49 : 0;
      recv_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 38 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        case ($urandom_range(0, 5))
          0:       set_radius(dvcl_pkg::VmaxReset);
          1:       set_radius(15'($urandom_range(0, 15)));
          2:       set_radius(15'(32767 - $urandom_range(0, 15)));
          default: set_radius(15'($urandom_range(0, 32767)));
        endcase
        v = int'(radius);
        for (int n = 0; n < SegItems; n++) begin
          if (seg == 1 && n == 0) hold_req = 1'b1;   // receiver stalls, input backs up
          if (seg == 3 && n == 50) drain_results();
          case ($urandom_range(0, 3))
            0: begin   // anything in range
              ud_v = $urandom_range(0, 65535) - 32768;
              uq_v = $urandom_range(0, 65535) - 32768;
            end
            1: begin   // well inside
              ud_v = $urandom_range(0, v / 2);
              uq_v = $urandom_range(0, v / 2);
            end
            2: begin   // close to the circle, q side
              ud_v = $urandom_range(0, v);
              r_v  = int'(root_floor(longint'(v) * v - longint'(ud_v) * ud_v));
              uq_v = r_v + $urandom_range(0, 4) - 2;
              if (uq_v < 0) uq_v = 0;
            end
            default: begin   // d axis at the radius
              ud_v = v + $urandom_range(0, 6) - 3;
              if (ud_v < 0) ud_v = 0;
              uq_v = $urandom_range(0, 65535) - 32768;
            end
          endcase
          if (ud_v > 32767) ud_v = 32767;
          if (uq_v > 32767) uq_v = 32767;
          if ($urandom_range(0, 1)) ud_v = -ud_v;
          if ($urandom_range(0, 1)) uq_v = -uq_v;
          e = limit_pair(ud_v[15:0], uq_v[15:0], radius);
          send_pair(ud_v[15:0], uq_v[15:0], e);
          rand_items++;
        end
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    $display("covered %0d directed and %0d random pairs, %0d radius writes", $size(dir_rows),
             rand_items, cfg_writes);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
